>>> sv/pbfs_pkg.sv
// ============================================================================
// Packed bit-field store: shared package
// Sizes, the field layout of the stream words and the entries-per-word table.
// ============================================================================
`default_nettype none

package pbfs_pkg;

    // Storage geometry
    localparam int WORD_BITS   = 64;
    localparam int WORD_DEPTH  = 2048;
    localparam int MAX_ENTRIES = 4096;
    localparam int ADDR_W      = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;

    // Field widths
    localparam int WIDTH_W   = 6;    // entry_width register
    localparam int COUNT_W   = 13;   // entry_count register
    localparam int IDX_W     = 12;   // entry_index field
    localparam int VAL_W     = 32;   // write_value and read_value fields
    localparam int SHIFT_W   = $clog2(WORD_BITS);
    localparam int PER_W     = SHIFT_W + 1;
    localparam int STEP_W    = $clog2(IDX_W);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = COUNT_W;

    // Stream word widths (padded to whole bytes)
    localparam int S_TDATA_W = ((IDX_W + VAL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VAL_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b1;

    // Commands
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Reset values of the configuration registers
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 6'd4;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

    // Number of whole entries that fit in one 64-bit word, for widths 1..32.
    function automatic logic [PER_W-1:0] per_word_of(input logic [WIDTH_W-1:0] w);
        logic [PER_W-1:0] n;
        unique case (w)
            6'd1:  n = 7'd64;
            6'd2:  n = 7'd32;
            6'd3:  n = 7'd21;
            6'd4:  n = 7'd16;
            6'd5:  n = 7'd12;
            6'd6:  n = 7'd10;
            6'd7:  n = 7'd9;
            6'd8:  n = 7'd8;
            6'd9:  n = 7'd7;
            6'd10: n = 7'd6;
            6'd11, 6'd12: n = 7'd5;
            6'd13, 6'd14, 6'd15, 6'd16: n = 7'd4;
            6'd17, 6'd18, 6'd19, 6'd20, 6'd21: n = 7'd3;
            6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27,
            6'd28, 6'd29, 6'd30, 6'd31, 6'd32: n = 7'd2;
            default: n = 7'd1;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

>>> sv/pbfs_ram.sv
// ============================================================================
// Packed bit-field store: generic RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module pbfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/packed_bit_field_store_top.sv
// ============================================================================
// Packed bit-field store
// Entries of 1 to 32 bits packed into 64-bit memory words, read or written
// one at a time by index through a shared restoring divider.
// ============================================================================
//
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser: command; tdata: index, value
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: read_value; tuser: range_error
// cfg       in   i_cfg_we (no wait)             i_cfg_addr, i_cfg_wdata
//
// A valid access runs one subtract-and-shift step of the divider per index
// bit (12), then the address, memory read and write-back states, and then
// loads the output register from the final state. A rejected or empty-store
// access goes from acceptance straight to the final state and loads it there.
// After reset, a clearing pass writes zero to all 2048 words;
// no word is accepted meanwhile, configuration writes are taken as usual.
// One access is in flight at a time; a held output word stalls only the end
// of the next access.
`default_nettype none

module packed_bit_field_store_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [pbfs_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  wire logic [pbfs_pkg::CFG_DAT_W-1:0]      i_cfg_wdata,
    // Access requests
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [11:0] entry_index, [43:12] write_value, [47:44] zero
    input  wire logic [pbfs_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // [0] command
    input  wire logic                                s_axis_tuser,
    // Access results
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [31:0] read_value
    output logic      [pbfs_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // [0] range_error
    output logic                                     m_axis_tuser
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DIV   = 6'b000100,
        S_ADDR  = 6'b001000,
        S_READ  = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [pbfs_pkg::WIDTH_W-1:0] r_entry_width;
    logic [pbfs_pkg::COUNT_W-1:0] r_entry_count;

    // Access context
    logic                           r_cmd;
    logic [pbfs_pkg::VAL_W-1:0]     r_val;
    logic [pbfs_pkg::WIDTH_W-1:0]   r_w;
    logic [pbfs_pkg::PER_W-1:0]     r_per;
    logic [pbfs_pkg::IDX_W-1:0]     r_quo;
    logic [pbfs_pkg::SHIFT_W-1:0]   r_rem;
    logic [pbfs_pkg::STEP_W-1:0]    r_step;
    logic [pbfs_pkg::SHIFT_W-1:0]   r_shift;
    logic [pbfs_pkg::VAL_W-1:0]     r_res_val;
    logic                           r_res_err;
    logic [pbfs_pkg::ADDR_W-1:0]    r_clr_addr;

    // Output register
    logic                           r_out_valid;
    logic [pbfs_pkg::VAL_W-1:0]     r_out_val;
    logic                           r_out_err;

    // Input fields
    logic [pbfs_pkg::IDX_W-1:0]     in_idx;
    logic [pbfs_pkg::VAL_W-1:0]     in_val;
    assign in_idx = s_axis_tdata[pbfs_pkg::IDX_W-1:0];
    assign in_val = s_axis_tdata[pbfs_pkg::IDX_W +: pbfs_pkg::VAL_W];

    // Effective width and count (saturated)
    logic [pbfs_pkg::WIDTH_W-1:0]   eff_w;
    logic [pbfs_pkg::COUNT_W-1:0]   eff_cnt;
    logic [pbfs_pkg::VAL_W-1:0]     in_mask;
    logic                           in_empty, in_past, in_wide, accept;

    always_comb begin
        if (r_entry_width == '0) begin
            eff_w = pbfs_pkg::WIDTH_W'(1);
        end else if (r_entry_width > pbfs_pkg::WIDTH_W'(pbfs_pkg::VAL_W)) begin
            eff_w = pbfs_pkg::WIDTH_W'(pbfs_pkg::VAL_W);
        end else begin
            eff_w = r_entry_width;
        end
        if (r_entry_count > pbfs_pkg::COUNT_W'(pbfs_pkg::MAX_ENTRIES)) begin
            eff_cnt = pbfs_pkg::COUNT_W'(pbfs_pkg::MAX_ENTRIES);
        end else begin
            eff_cnt = r_entry_count;
        end
        // Largest value that fits in one entry
        if (eff_w == pbfs_pkg::WIDTH_W'(pbfs_pkg::VAL_W)) begin
            in_mask = '1;
        end else begin
            in_mask = (pbfs_pkg::VAL_W'(1) << eff_w) - pbfs_pkg::VAL_W'(1);
        end
    end

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign in_empty = (eff_cnt == '0);
    assign in_past  = ({1'b0, in_idx} >= eff_cnt);
    assign in_wide  = (s_axis_tuser == pbfs_pkg::CMD_WRITE) && (in_val > in_mask);

    // Shared divider step: one quotient bit per cycle
    logic [pbfs_pkg::SHIFT_W:0]     div_trial;
    logic                           div_ge;
    assign div_trial = {r_rem, r_quo[pbfs_pkg::IDX_W-1]};
    assign div_ge    = (div_trial >= r_per);

    // Bit offset of the entry inside its word
    logic [2*pbfs_pkg::WIDTH_W-1:0] off_prod;
    assign off_prod = (2*pbfs_pkg::WIDTH_W)'(r_rem) * (2*pbfs_pkg::WIDTH_W)'(r_w);

    logic word_out;
    assign word_out = (32'(r_quo) >= 32'(pbfs_pkg::WORD_DEPTH));

    // Memory and read-modify-write merge
    logic                            ram_we, ram_re;
    logic [pbfs_pkg::ADDR_W-1:0]     ram_waddr;
    logic [pbfs_pkg::WORD_BITS-1:0]  ram_wdata, ram_rdata;
    logic [pbfs_pkg::WORD_BITS-1:0]  fld_mask, merged, extracted;

    assign fld_mask  = (pbfs_pkg::WORD_BITS'(1) << r_w) - pbfs_pkg::WORD_BITS'(1);
    assign extracted = (ram_rdata >> r_shift) & fld_mask;
    assign merged    = (ram_rdata & ~(fld_mask << r_shift))
                     | (pbfs_pkg::WORD_BITS'(r_val) << r_shift);

    assign ram_re    = (r_state == S_ADDR);
    assign ram_we    = (r_state == S_CLEAR)
                     || ((r_state == S_READ) && (r_cmd == pbfs_pkg::CMD_WRITE));
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_quo[pbfs_pkg::ADDR_W-1:0];
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : merged;

    pbfs_ram #(
        .WIDTH (pbfs_pkg::WORD_BITS),
        .DEPTH (pbfs_pkg::WORD_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_quo[pbfs_pkg::ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    logic out_free;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == pbfs_pkg::ADDR_W'(pbfs_pkg::WORD_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = (in_empty || in_past || in_wide) ? S_FIN : S_DIV;
                end
            end
            S_DIV: begin
                if (r_step == pbfs_pkg::STEP_W'(pbfs_pkg::IDX_W - 1)) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR:  n_state = word_out ? S_FIN : S_READ;
            S_READ:  n_state = S_FIN;
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_entry_width <= pbfs_pkg::WIDTH_RESET;
            r_entry_count <= pbfs_pkg::COUNT_RESET;
            r_out_valid   <= 1'b0;
            r_step        <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + pbfs_pkg::ADDR_W'(1);
            end
            // Configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    pbfs_pkg::CFG_ENTRY_WIDTH:
                        r_entry_width <= i_cfg_wdata[pbfs_pkg::WIDTH_W-1:0];
                    pbfs_pkg::CFG_ENTRY_COUNT:
                        r_entry_count <= i_cfg_wdata;
                    default: ;
                endcase
            end
            // Divider step counter
            if (r_state == S_DIV) begin
                r_step <= r_step + pbfs_pkg::STEP_W'(1);
            end else begin
                r_step <= '0;
            end
            // Output valid
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_cmd     <= s_axis_tuser;
                r_val     <= in_val;
                r_w       <= eff_w;
                r_per     <= pbfs_pkg::per_word_of(eff_w);
                r_quo     <= in_idx;
                r_rem     <= '0;
                r_res_val <= '0;
                r_res_err <= !in_empty && (in_past || in_wide);
            end
            S_DIV: begin
                r_quo <= {r_quo[pbfs_pkg::IDX_W-2:0], div_ge};
                r_rem <= div_ge ? pbfs_pkg::SHIFT_W'(div_trial - r_per)
                                : div_trial[pbfs_pkg::SHIFT_W-1:0];
            end
            S_ADDR: begin
                r_shift   <= off_prod[pbfs_pkg::SHIFT_W-1:0];
                r_res_err <= word_out;
            end
            S_READ: begin
                r_res_val <= (r_cmd == pbfs_pkg::CMD_READ)
                           ? extracted[pbfs_pkg::VAL_W-1:0] : '0;
            end
            default: ;
        endcase
        if ((r_state == S_FIN) && out_free) begin
            r_out_val <= r_res_val;
            r_out_err <= r_res_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = pbfs_pkg::M_TDATA_W'(r_out_val);
    assign m_axis_tuser  = r_out_err;

    // Checks
    ast_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("request accepted during the clearing pass");

    ast_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("second request accepted while one is in flight");

    ast_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("rejected access returned a nonzero value");

    ast_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (r_state != S_CLEAR)) |-> (r_cmd == pbfs_pkg::CMD_WRITE && !r_res_err))
        else $error("memory written by a read or a rejected access");

endmodule

`default_nettype wire
